/* design/oaat16_pkg.sv */
// Package with the shared types and mixing functions of the two-byte one-at-a-time hash.
package oaat16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned HashW = 32;

  // Shift amounts of the per-word mix.
  localparam int unsigned MixShl = 10;
  localparam int unsigned MixShr = 6;

  // Shift amounts of the finalization.
  localparam int unsigned FinShl1 = 3;
  localparam int unsigned FinShr  = 11;
  localparam int unsigned FinShl2 = 15;

  // A finished accumulator that is on its way to the finalization stage.
  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] acc;
  } fin_t;

  // Mixes one 16-bit word into the accumulator.
  function automatic logic [HashW-1:0] mix_word(input logic [HashW-1:0] acc,
                                                input logic [2*ByteW-1:0] word);
    logic [HashW-1:0] a;
    a = acc + {{(HashW-2*ByteW){1'b0}}, word};
    a = a + (a << MixShl);
    a = a ^ (a >> MixShr);
    return a;
  endfunction

  // Final avalanche of the accumulator.
  function automatic logic [HashW-1:0] finish(input logic [HashW-1:0] acc);
    logic [HashW-1:0] a;
    a = acc + (acc << FinShl1);
    a = a ^ (a >> FinShr);
    a = a + (a << FinShl2);
    return a;
  endfunction

endpackage

/* design/oaat16_if.sv */
// Handshake channel interfaces for key bytes in and hash values out.
interface oaat16_in_if import oaat16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] key_byte;
  logic             byte_present;
  logic             end_of_key;

  modport source (output valid, key_byte, byte_present, end_of_key, input ready);
  modport sink   (input valid, key_byte, byte_present, end_of_key, output ready);
endinterface

interface oaat16_out_if import oaat16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HashW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

/* design/oaat16_mix.sv */
// Input register, running accumulator and per-word mix of the hash.
module oaat16_mix import oaat16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  oaat16_in_if.sink   key_i,
  input  logic        fin_ready_i,
  output fin_t        fin_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] key_byte_q;
  logic             present_q;
  logic             last_q;

  logic [HashW-1:0] acc_q, acc_d;
  logic [ByteW-1:0] held_byte_q, held_byte_d;
  logic             held_valid_q, held_valid_d;

  logic             fin_valid_q, fin_valid_d;
  logic [HashW-1:0] fin_acc_q, fin_acc_d;

  logic             fin_adv;
  logic             step;
  logic             do_mix;
  logic [2*ByteW-1:0] word;
  logic [HashW-1:0] acc_new;

  // The stage moves when the finalization register can take a word.
  assign fin_adv     = !fin_valid_q || fin_ready_i;
  assign step        = in_valid_q && fin_adv;
  assign key_i.ready = !in_valid_q || fin_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (key_i.valid && key_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      key_byte_q <= key_i.key_byte;
      present_q  <= key_i.byte_present;
      last_q     <= key_i.end_of_key;
    end
  end

  // Pick the word to mix: a completed pair, or a lone byte at the end of the key.
  always_comb begin
    do_mix       = 1'b0;
    word         = '0;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    if (present_q && held_valid_q) begin
      do_mix       = 1'b1;
      word         = {key_byte_q, held_byte_q};
      held_valid_d = 1'b0;
      held_byte_d  = '0;
    end else if (present_q) begin
      if (last_q) begin
        do_mix = 1'b1;
        word   = {{ByteW{1'b0}}, key_byte_q};
      end else begin
        held_valid_d = 1'b1;
        held_byte_d  = key_byte_q;
      end
    end else if (last_q && held_valid_q) begin
      do_mix = 1'b1;
      word   = {{ByteW{1'b0}}, held_byte_q};
    end
    acc_new = do_mix ? mix_word(acc_q, word) : acc_q;
  end

  // State update and hand-off of a finished key.
  always_comb begin
    acc_d       = acc_q;
    fin_valid_d = fin_valid_q;
    fin_acc_d   = fin_acc_q;
    if (fin_ready_i) begin
      fin_valid_d = 1'b0;
    end
    if (step) begin
      if (last_q) begin
        acc_d       = '0;
        fin_valid_d = 1'b1;
        fin_acc_d   = acc_new;
      end else begin
        acc_d = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      fin_valid_q  <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      if (step) begin
        acc_q        <= acc_d;
        held_byte_q  <= last_q ? '0 : held_byte_d;
        held_valid_q <= last_q ? 1'b0 : held_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_acc_q <= fin_acc_d;
  end

  assign fin_o = '{valid: fin_valid_q, acc: fin_acc_q};

endmodule

/* design/oaat16_fin.sv */
// Finalization of a key's accumulator and the output register.
module oaat16_fin import oaat16_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fin_t         fin_i,
  output logic         fin_ready_o,
  oaat16_out_if.source hash_o
);

  logic             out_valid_q;
  logic [HashW-1:0] hash_q;
  logic             load;

  // The output register takes a new word when it is empty or being drained.
  assign fin_ready_o = !out_valid_q || hash_o.ready;
  assign load        = fin_i.valid && fin_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_ready_o) begin
      out_valid_q <= fin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hash_q <= finish(fin_i.acc);
    end
  end

  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = hash_q;

endmodule

/* design/one_at_a_time_hash_16bit_top.sv */
// Top level of the streaming two-byte one-at-a-time key hash.
//
// key_i carries one word per cycle: a key byte, a flag that the byte is
// present, and an end-of-key flag. Bytes are paired low byte first into
// 16-bit words and mixed into a 32-bit accumulator. The word that ends a key
// produces one word on hash_o with the finalized hash; all other words
// produce nothing. An end-of-key word with no byte and no earlier bytes
// gives a hash of zero.
// Throughput is one word per cycle while key_i.ready is high. The result of
// an end-of-key word is mixed in the mixing stage behind the input register,
// then passes to the finalization stage, which finalizes it into the output
// register that drives hash_o.
// Reset clears the accumulator, the held byte and all valid flags, so the
// next word starts a new key. When the receiver holds hash_o.ready low, the
// result stays in the output register. Words that do not end a key are still
// taken; key_i.ready falls only once a second finished key waits in the
// finalization stage and one more word sits in the input register. No word
// is lost or repeated.
module one_at_a_time_hash_16bit_top import oaat16_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  oaat16_in_if.sink    key_i,
  oaat16_out_if.source hash_o
);

  fin_t fin;
  logic fin_ready;

  oaat16_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_i),
    .fin_ready_i (fin_ready),
    .fin_o       (fin)
  );

  oaat16_fin u_fin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_i       (fin),
    .fin_ready_o (fin_ready),
    .hash_o      (hash_o)
  );

endmodule

/* bench/tb.sv */
// Testbench for the streaming two-byte one-at-a-time key hash top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaat16_pkg::*;

  // One word on the key channel, plus a flag that holds it back until all hashes are out.
  typedef struct packed {
    logic [ByteW-1:0] key_byte;
    logic             byte_present;
    logic             end_of_key;
    logic             wait_drain;
  } key_word_t;

  logic clk_i;
  logic rst_ni;

  oaat16_in_if  key_if ();
  oaat16_out_if hash_if ();

  one_at_a_time_hash_16bit_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .hash_o (hash_if)
  );

  key_word_t        pending_words[$];
  logic [HashW-1:0] expected_hashes[$];
  int unsigned      fail_count;
  int unsigned      key_words_queued;
  logic             drain_next;

  // Running state of the predicted hash.
  logic [HashW-1:0] running_hash;
  logic [ByteW-1:0] low_byte;
  logic             low_byte_held;

  logic             word_accepted;
  int unsigned      send_gap;
  int unsigned      stall_left;
  logic             send_calm;
  logic             sink_calm;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = ~clk_i;
  end

  // One word of the per-word mixing step.
  function automatic logic [HashW-1:0] hash_mix(input logic [HashW-1:0] acc,
                                                input logic [2*ByteW-1:0] word);
    logic [HashW-1:0] h;
    h = acc + HashW'(word);
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // Final avalanche applied when a key ends.
  function automatic logic [HashW-1:0] hash_finalize(input logic [HashW-1:0] acc);
    logic [HashW-1:0] h;
    h = acc + (acc << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // Gap length: mostly none or short, now and then long, none at all in a calm phase.
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Key bytes lean toward the extremes.
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic add_word(input logic [ByteW-1:0] b, input logic present, input logic last);
    key_word_t w;
    w.key_byte     = b;
    w.byte_present = present;
    w.end_of_key   = last;
    w.wait_drain   = drain_next;
    drain_next     = 1'b0;
    pending_words.push_back(w);
    if (present || last) key_words_queued++;
  endtask

  // Updates the predicted state with one accepted word and queues the hash it gives.
  task automatic predict_hash(input logic [ByteW-1:0] b, input logic present,
                              input logic last);
    if (present) begin
      if (low_byte_held) begin
        running_hash  = hash_mix(running_hash, {b, low_byte});
        low_byte      = '0;
        low_byte_held = 1'b0;
      end else begin
        low_byte      = b;
        low_byte_held = 1'b1;
      end
    end
    if (last) begin
      if (low_byte_held) running_hash = hash_mix(running_hash, {{ByteW{1'b0}}, low_byte});
      expected_hashes.push_back(hash_finalize(running_hash));
      running_hash  = '0;
      low_byte      = '0;
      low_byte_held = 1'b0;
    end
  endtask

  // Sender: presents the next word at the falling edge once the current one is taken.
  always @(negedge clk_i) begin
    key_word_t w;
    if (rst_ni) begin
      if (key_if.valid && !word_accepted) begin
        // Hold the word until the block takes it.
      end else if (send_gap != 0) begin
        send_gap--;
        key_if.valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].wait_drain && expected_hashes.size() != 0)) begin
        key_if.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        key_if.key_byte     <= w.key_byte;
        key_if.byte_present <= w.byte_present;
        key_if.end_of_key   <= w.end_of_key;
        key_if.valid        <= 1'b1;
        if ($urandom_range(0, 49) == 0) send_calm = ~send_calm;
        send_gap = pick_gap(send_calm);
      end
    end
  end

  // Receiver: random stalls on the hash channel.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        hash_if.ready <= 1'b0;
      end else begin
        hash_if.ready <= 1'b1;
        if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
        stall_left = pick_gap(sink_calm);
      end
    end
  end

  // Monitor: predicts on each accepted key word and checks each accepted hash word.
  always @(posedge clk_i) begin
    logic [HashW-1:0] want;
    if (rst_ni) begin
      word_accepted <= key_if.valid && key_if.ready;
      if (key_if.valid && key_if.ready)
        predict_hash(key_if.key_byte, key_if.byte_present, key_if.end_of_key);
      if (hash_if.valid && hash_if.ready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value %h arrived with no hash expected", hash_if.hash_value);
          fail_count++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_if.hash_value !== want) begin
            $error("hash_value mismatch: expected %h, actual %h", want, hash_if.hash_value);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned key_len;
    logic        end_with_byte;
    rst_ni              = 1'b0;
    key_if.valid        = 1'b0;
    key_if.key_byte     = '0;
    key_if.byte_present = 1'b0;
    key_if.end_of_key   = 1'b0;
    hash_if.ready       = 1'b0;
    fail_count          = 0;
    key_words_queued    = 0;
    drain_next          = 1'b0;
    running_hash        = '0;
    low_byte            = '0;
    low_byte_held       = 1'b0;
    word_accepted       = 1'b0;
    send_gap            = 0;
    stall_left          = 0;
    send_calm           = 1'b0;
    sink_calm           = 1'b0;

    // Directed keys: empty key with a stray byte value, single extreme bytes,
    // an even key closed by an empty last word, an idle word inside a key,
    // odd lengths, and an even key closed by a byte.
    add_word(8'hFF, 1'b0, 1'b1);
    add_word(8'hFF, 1'b1, 1'b1);
    add_word(8'h00, 1'b1, 1'b1);
    add_word(8'hFF, 1'b1, 1'b0);
    add_word(8'hFF, 1'b1, 1'b0);
    add_word(8'hA5, 1'b0, 1'b1);
    add_word(8'h12, 1'b1, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(8'h34, 1'b1, 1'b0);
    add_word(8'h56, 1'b1, 1'b1);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'hAB, 1'b1, 1'b0);
    add_word(8'hCD, 1'b1, 1'b1);
    add_word(8'h80, 1'b1, 1'b0);
    add_word(8'h01, 1'b0, 1'b1);
    add_word(8'h00, 1'b0, 1'b1);

    // Random keys, mostly short, a few long, with idle words and stray byte values.
    drain_next = 1'b1;
    while (key_words_queued < 490) begin
      if ($urandom_range(0, 9) == 0) add_word(pick_byte(), 1'b0, 1'b0);
      if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
      key_len       = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 8);
      end_with_byte = (key_len != 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < key_len; i++) begin
        if ($urandom_range(0, 7) == 0) add_word(pick_byte(), 1'b0, 1'b0);
        add_word(pick_byte(), 1'b1, end_with_byte && (i == key_len - 1));
      end
      if (!end_with_byte) add_word(pick_byte(), 1'b0, 1'b1);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_words.size() == 0 && !key_if.valid);
    wait (expected_hashes.size() == 0);
    repeat (10) @(posedge clk_i);
    if (expected_hashes.size() != 0) begin
      $error("%0d hash values never arrived", expected_hashes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
design/oaat16_pkg.sv
design/oaat16_if.sv
design/oaat16_mix.sv
design/oaat16_fin.sv
design/one_at_a_time_hash_16bit_top.sv
bench/tb.sv
